// ----- src/max_flow_dinic_assert.svh -----
// ---------------------------------------------------------------------------
// max_flow_dinic assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef MAX_FLOW_DINIC_ASSERT_SVH
`define MAX_FLOW_DINIC_ASSERT_SVH

// condition must never hold
`define MFD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("max_flow_dinic: assertion failed");

// antecedent implies consequent on the next cycle
`define MFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("max_flow_dinic: assertion failed");

`endif

// ----- src/mfd_pkg.sv -----
// ---------------------------------------------------------------------------
// mfd_pkg
// shared types, constants and state codes of the max flow block
// ---------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 256;
	localparam int QUEUE_DEPTH   = 4;
	localparam int PADDR_W       = 4;
	localparam int CAP_W         = 32;
	localparam int FLOW_OUT_W    = 40;
	localparam int NODE_IN_W     = 6;
	localparam int COUNT_W       = 7;
	localparam int IN_DATA_W     = 48;

	typedef enum logic [1:0] {
		REG_NODE_COUNT  = 2'd0,
		REG_SOURCE_NODE = 2'd1,
		REG_SINK_NODE   = 2'd2
	} reg_idx_t;

	// one edge word as classified by the front
	typedef struct packed {
		logic [NODE_IN_W-1:0] from_node;
		logic [NODE_IN_W-1:0] to_node;
		logic [CAP_W-1:0]     capacity;
		logic                 last_edge;
		logic                 bad_node;
	} item_t;

	// terminals as seen by the engine
	typedef struct packed {
		logic [NODE_IN_W-1:0] source_node;
		logic [NODE_IN_W-1:0] sink_node;
		logic                 term_bad;
	} cfg_t;

	typedef enum logic [5:0] {
		B_IDLE, B_LINK_RD0, B_LINK_WR0, B_LINK_RD1, B_LINK_WR1, B_CHECK,
		B_LVL_CLR, B_LVL_SEED, B_BFS_POP, B_BFS_V, B_BFS_VL, B_BFS_E,
		B_BFS_EA, B_BFS_EL, B_CUR_RD, B_CUR_WR, B_DFS_START, B_DFS_V,
		B_DFS_C, B_DFS_E, B_DFS_EA, B_DFS_EL, B_DFS_PUSH, B_DFS_FAIL,
		B_DFS_RET, B_DFS_RW, B_DFS_RN, B_DFS_RT, B_AUG_RD, B_AUG_S,
		B_AUG_M, B_UPD_RD, B_UPD_S, B_UPD_F, B_UPD_G, B_DONE
	} back_state_t;

endpackage

`default_nettype wire

// ----- src/mfd_ram.sv -----
// ---------------------------------------------------------------------------
// mfd_ram
// generic simple dual port ram, one write port, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module mfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/mfd_queue.sv -----
// ---------------------------------------------------------------------------
// mfd_queue
// short fifo of classified edge words between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module mfd_queue import mfd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/mfd_front.sv -----
// ---------------------------------------------------------------------------
// mfd_front
// register port, edge intake and node range check
// ---------------------------------------------------------------------------
`default_nettype none

module mfd_front import mfd_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic                 s_tlast,
	input  wire logic                 q_full,
	output logic                      q_push,
	output item_t                     q_item,
	output cfg_t                      cfg
);

	logic [COUNT_W-1:0]   node_count_q;
	logic [NODE_IN_W-1:0] source_node_q;
	logic [NODE_IN_W-1:0] sink_node_q;
	logic [31:0]          n_eff;
	logic                 wr_en;
	logic [NODE_IN_W-1:0] from_node;
	logic [NODE_IN_W-1:0] to_node;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= COUNT_W'(64);
			source_node_q <= '0;
			sink_node_q   <= NODE_IN_W'(1);
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_NODE_COUNT:  node_count_q  <= pwdata[COUNT_W-1:0];
				REG_SOURCE_NODE: source_node_q <= pwdata[NODE_IN_W-1:0];
				REG_SINK_NODE:   sink_node_q   <= pwdata[NODE_IN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NODE_COUNT:  prdata = 32'(node_count_q);
			REG_SOURCE_NODE: prdata = 32'(source_node_q);
			REG_SINK_NODE:   prdata = 32'(sink_node_q);
			default:         prdata = '0;
		endcase
	end

	// node count clamps at the store size
	assign n_eff = (32'(node_count_q) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(node_count_q);

	assign from_node = s_tdata[5:0];
	assign to_node   = s_tdata[11:6];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.from_node = from_node;
		q_item.to_node   = to_node;
		q_item.capacity  = s_tdata[43:12];
		q_item.last_edge = s_tlast;
		q_item.bad_node  = (32'(from_node) >= n_eff) || (32'(to_node) >= n_eff);
	end

	always_comb begin
		cfg.source_node = source_node_q;
		cfg.sink_node   = sink_node_q;
		cfg.term_bad    = (source_node_q == sink_node_q) || (32'(source_node_q) >= n_eff)
			|| (32'(sink_node_q) >= n_eff);
	end

endmodule

`default_nettype wire

// ----- src/mfd_back.sv -----
// ---------------------------------------------------------------------------
// mfd_back
// graph store and dinic sequencer: bfs levels, blocking paths, result
// ---------------------------------------------------------------------------
`default_nettype none

`include "max_flow_dinic_assert.svh"

module mfd_back import mfd_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  q_empty,
	input  wire item_t                 q_item,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [FLOW_OUT_W-1:0]      m_tdata,
	output logic                       m_tuser
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int LVL_W  = $clog2(MAX_NODES + 1);
	localparam int DEP_W  = LVL_W;
	localparam int SLOT_W = $clog2(2 * MAX_EDGES);
	localparam int PTR_W  = $clog2(2 * MAX_EDGES + 1);
	localparam int CNT_W  = $clog2(MAX_EDGES + 1);
	localparam int EW     = NODE_W + CAP_W + PTR_W;
	localparam int FW     = CAP_W + 1;

	localparam logic [PTR_W-1:0] NIL       = PTR_W'(2 * MAX_EDGES);
	localparam logic [LVL_W-1:0] LVL_NONE  = LVL_W'(MAX_NODES);
	localparam logic [DEP_W-1:0] DEP_MAX   = DEP_W'(MAX_NODES);
	localparam logic [DEP_W-1:0] LAST_NODE = DEP_W'(MAX_NODES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_EDGES);

	back_state_t state_q, state_d;

	item_t               item_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                err_q;
	logic                tb_q;
	logic [MAX_NODES-1:0] fv_q;
	logic                fv_hit_q;
	logic [DEP_W-1:0]    i_q, qh_q, qt_q, depth_q;
	logic [NODE_W-1:0]   v_q, h_q;
	logic [LVL_W-1:0]    lv_q;
	logic [PTR_W-1:0]    e_q, nxt_q;
	logic [SLOT_W-1:0]   pe_q;
	logic [CAP_W-1:0]    b_q;
	logic [FLOW_OUT_W-1:0] total_q;
	logic                tfound_q;
	logic                out_valid_q;
	logic [FLOW_OUT_W-1:0] out_flow_q;
	logic                out_err_q;

	// memory ports
	logic              edge_we;
	logic [SLOT_W-1:0] edge_waddr, edge_raddr;
	logic [EW-1:0]     edge_wdata, edge_rdata;
	logic              flow_we;
	logic [SLOT_W-1:0] flow_waddr, flow_raddr;
	logic [FW-1:0]     flow_wdata, flow_rdata;
	logic              first_we;
	logic [NODE_W-1:0] first_waddr, first_raddr;
	logic [SLOT_W-1:0] first_wdata, first_rdata;
	logic              level_we;
	logic [NODE_W-1:0] level_waddr, level_raddr;
	logic [LVL_W-1:0]  level_wdata, level_rdata;
	logic              cur_we;
	logic [NODE_W-1:0] cur_waddr, cur_raddr;
	logic [PTR_W-1:0]  cur_wdata, cur_rdata;
	logic              bq_we;
	logic [NODE_W-1:0] bq_waddr, bq_raddr;
	logic [NODE_W-1:0] bq_wdata, bq_rdata;
	logic              stk_we;
	logic [NODE_W-1:0] stk_waddr, stk_raddr;
	logic [SLOT_W-1:0] stk_wdata, stk_rdata;

	// decoded values
	logic [NODE_W-1:0] ed_head;
	logic [CAP_W-1:0]  ed_cap;
	logic [PTR_W-1:0]  ed_next;
	logic [PTR_W-1:0]  first_eff;
	logic [CAP_W+1:0]  res_full;
	logic              res_pos;
	logic [CAP_W-1:0]  res32;
	logic [LVL_W-1:0]  lv_inc;
	logic [DEP_W-1:0]  i_inc;
	logic              i_last;
	logic [NODE_W-1:0] s_node, t_node, fr_node, to_node;
	logic [SLOT_W-1:0] slot;
	logic              store_full;
	logic              load;

	assign ed_head   = edge_rdata[EW-1 -: NODE_W];
	assign ed_cap    = edge_rdata[PTR_W +: CAP_W];
	assign ed_next   = edge_rdata[PTR_W-1:0];
	assign first_eff = fv_hit_q ? PTR_W'(first_rdata) : NIL;
	assign res_full  = {2'b00, ed_cap} - {flow_rdata[FW-1], flow_rdata};
	assign res_pos   = !res_full[CAP_W+1] && (res_full != '0);
	assign res32     = res_full[CAP_W-1:0];
	assign lv_inc    = lv_q + 1'b1;
	assign i_inc     = i_q + 1'b1;
	assign i_last    = (i_inc == depth_q);
	assign s_node    = NODE_W'(cfg.source_node);
	assign t_node    = NODE_W'(cfg.sink_node);
	assign fr_node   = NODE_W'(item_q.from_node);
	assign to_node   = NODE_W'(item_q.to_node);
	assign slot      = SLOT_W'({cnt_q, 1'b0});
	assign store_full = (cnt_q >= CNT_MAX);
	assign load      = (state_q == B_DONE) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_flow_q;
	assign m_tuser  = out_err_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_item.bad_node || store_full)
						state_d = q_item.last_edge ? B_CHECK : B_IDLE;
					else
						state_d = B_LINK_RD0;
				end
			end
			B_LINK_RD0: state_d = B_LINK_WR0;
			B_LINK_WR0: state_d = B_LINK_RD1;
			B_LINK_RD1: state_d = B_LINK_WR1;
			B_LINK_WR1: state_d = item_q.last_edge ? B_CHECK : B_IDLE;
			B_CHECK:    state_d = cfg.term_bad ? B_DONE : B_LVL_CLR;
			B_LVL_CLR:  state_d = (i_q == LAST_NODE) ? B_LVL_SEED : B_LVL_CLR;
			B_LVL_SEED: state_d = B_BFS_POP;
			B_BFS_POP: begin
				if ((qh_q < qt_q) && !tfound_q) state_d = B_BFS_V;
				else state_d = tfound_q ? B_CUR_RD : B_DONE;
			end
			B_BFS_V:    state_d = B_BFS_VL;
			B_BFS_VL:   state_d = B_BFS_E;
			B_BFS_E:    state_d = (e_q == NIL) ? B_BFS_POP : B_BFS_EA;
			B_BFS_EA:   state_d = res_pos ? B_BFS_EL : B_BFS_E;
			B_BFS_EL:   state_d = B_BFS_E;
			B_CUR_RD:   state_d = B_CUR_WR;
			B_CUR_WR:   state_d = (i_q == LAST_NODE) ? B_DFS_START : B_CUR_RD;
			B_DFS_START: state_d = B_DFS_V;
			B_DFS_V:    state_d = (v_q == t_node) ? B_AUG_RD : B_DFS_C;
			B_DFS_C:    state_d = B_DFS_E;
			B_DFS_E:    state_d = (e_q == NIL) ? B_DFS_FAIL : B_DFS_EA;
			B_DFS_EA:   state_d = res_pos ? B_DFS_EL : B_DFS_E;
			B_DFS_EL:   state_d = (level_rdata == lv_inc) ? B_DFS_PUSH : B_DFS_E;
			B_DFS_PUSH: state_d = (depth_q < DEP_MAX) ? B_DFS_V : B_DFS_RET;
			B_DFS_FAIL: state_d = B_DFS_RET;
			B_DFS_RET:  state_d = (depth_q == '0) ? B_LVL_CLR : B_DFS_RW;
			B_DFS_RW:   state_d = B_DFS_RN;
			B_DFS_RN:   state_d = B_DFS_RT;
			B_DFS_RT:   state_d = B_DFS_V;
			B_AUG_RD:   state_d = B_AUG_S;
			B_AUG_S:    state_d = B_AUG_M;
			B_AUG_M:    state_d = i_last ? B_UPD_RD : B_AUG_RD;
			B_UPD_RD:   state_d = B_UPD_S;
			B_UPD_S:    state_d = B_UPD_F;
			B_UPD_F:    state_d = B_UPD_G;
			B_UPD_G:    state_d = i_last ? B_DFS_V : B_UPD_RD;
			B_DONE:     state_d = load ? B_IDLE : B_DONE;
			default:    state_d = B_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		q_pop       = 1'b0;
		edge_we     = 1'b0;
		edge_waddr  = slot;
		edge_wdata  = '0;
		edge_raddr  = e_q[SLOT_W-1:0];
		flow_we     = 1'b0;
		flow_waddr  = slot;
		flow_wdata  = '0;
		flow_raddr  = e_q[SLOT_W-1:0];
		first_we    = 1'b0;
		first_waddr = fr_node;
		first_wdata = slot;
		first_raddr = fr_node;
		level_we    = 1'b0;
		level_waddr = h_q;
		level_wdata = lv_inc;
		level_raddr = ed_head;
		cur_we      = 1'b0;
		cur_waddr   = v_q;
		cur_wdata   = e_q;
		cur_raddr   = v_q;
		bq_we       = 1'b0;
		bq_waddr    = qt_q[NODE_W-1:0];
		bq_wdata    = h_q;
		bq_raddr    = qh_q[NODE_W-1:0];
		stk_we      = 1'b0;
		stk_waddr   = depth_q[NODE_W-1:0];
		stk_wdata   = e_q[SLOT_W-1:0];
		stk_raddr   = i_q[NODE_W-1:0];
		case (state_q)
			B_IDLE:     q_pop = !q_empty;
			B_LINK_RD0: first_raddr = fr_node;
			B_LINK_WR0: begin
				edge_we    = 1'b1;
				edge_wdata = {to_node, item_q.capacity, first_eff};
				flow_we    = 1'b1;
				first_we   = 1'b1;
			end
			B_LINK_RD1: first_raddr = to_node;
			B_LINK_WR1: begin
				edge_we     = 1'b1;
				edge_waddr  = slot | SLOT_W'(1);
				edge_wdata  = {fr_node, {CAP_W{1'b0}}, first_eff};
				flow_we     = 1'b1;
				flow_waddr  = slot | SLOT_W'(1);
				first_we    = 1'b1;
				first_waddr = to_node;
				first_wdata = slot | SLOT_W'(1);
			end
			B_LVL_CLR: begin
				level_we    = 1'b1;
				level_waddr = i_q[NODE_W-1:0];
				level_wdata = LVL_NONE;
			end
			B_LVL_SEED: begin
				level_we    = 1'b1;
				level_waddr = s_node;
				level_wdata = '0;
				bq_we       = 1'b1;
				bq_waddr    = '0;
				bq_wdata    = s_node;
			end
			B_BFS_POP: bq_raddr = qh_q[NODE_W-1:0];
			B_BFS_V: begin
				level_raddr = bq_rdata;
				first_raddr = bq_rdata;
			end
			B_BFS_EA, B_DFS_EA: level_raddr = ed_head;
			B_BFS_EL: begin
				if (lv_inc < level_rdata) begin
					level_we = 1'b1;
					bq_we    = (qt_q < DEP_MAX);
				end
			end
			B_CUR_RD: first_raddr = i_q[NODE_W-1:0];
			B_CUR_WR: begin
				cur_we    = 1'b1;
				cur_waddr = i_q[NODE_W-1:0];
				cur_wdata = first_eff;
			end
			B_DFS_V: cur_raddr = v_q;
			B_DFS_PUSH: begin
				cur_we = 1'b1;
				stk_we = (depth_q < DEP_MAX);
			end
			B_DFS_FAIL: begin
				cur_we    = 1'b1;
				cur_wdata = NIL;
			end
			B_DFS_RET: stk_raddr = NODE_W'(depth_q - 1'b1);
			B_DFS_RW:  edge_raddr = stk_rdata;
			B_DFS_RN:  edge_raddr = pe_q ^ SLOT_W'(1);
			B_DFS_RT: begin
				cur_we    = 1'b1;
				cur_waddr = ed_head;
				cur_wdata = nxt_q;
			end
			B_AUG_RD: stk_raddr = i_q[NODE_W-1:0];
			B_AUG_S: begin
				edge_raddr = stk_rdata;
				flow_raddr = stk_rdata;
			end
			B_UPD_RD: stk_raddr = i_q[NODE_W-1:0];
			B_UPD_S:  flow_raddr = stk_rdata;
			B_UPD_F: begin
				flow_we    = 1'b1;
				flow_waddr = pe_q;
				flow_wdata = flow_rdata + FW'(b_q);
				flow_raddr = pe_q ^ SLOT_W'(1);
			end
			B_UPD_G: begin
				flow_we    = 1'b1;
				flow_waddr = pe_q ^ SLOT_W'(1);
				flow_wdata = flow_rdata - FW'(b_q);
			end
			default: ;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			item_q      <= '0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			tb_q        <= 1'b0;
			fv_q        <= '0;
			fv_hit_q    <= 1'b0;
			i_q         <= '0;
			qh_q        <= '0;
			qt_q        <= '0;
			depth_q     <= '0;
			v_q         <= '0;
			h_q         <= '0;
			lv_q        <= '0;
			e_q         <= '0;
			nxt_q       <= '0;
			pe_q        <= '0;
			b_q         <= '0;
			total_q     <= '0;
			tfound_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_flow_q  <= '0;
			out_err_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			fv_hit_q <= fv_q[first_raddr];
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						item_q <= q_item;
						if (q_item.bad_node || store_full) err_q <= 1'b1;
					end
				end
				B_LINK_WR0: fv_q[fr_node] <= 1'b1;
				B_LINK_WR1: begin
					fv_q[to_node] <= 1'b1;
					cnt_q         <= cnt_q + 1'b1;
				end
				B_CHECK: begin
					tb_q    <= cfg.term_bad;
					total_q <= '0;
					i_q     <= '0;
				end
				B_LVL_CLR: i_q <= (i_q == LAST_NODE) ? '0 : i_inc;
				B_LVL_SEED: begin
					qh_q     <= '0;
					qt_q     <= DEP_W'(1);
					tfound_q <= 1'b0;
				end
				B_BFS_POP: begin
					if ((qh_q < qt_q) && !tfound_q) qh_q <= qh_q + 1'b1;
					else i_q <= '0;
				end
				B_BFS_V: v_q <= bq_rdata;
				B_BFS_VL: begin
					lv_q <= level_rdata;
					e_q  <= first_eff;
				end
				B_BFS_EA, B_DFS_EA: begin
					h_q   <= ed_head;
					nxt_q <= ed_next;
					if (!res_pos) e_q <= ed_next;
				end
				B_BFS_EL: begin
					if (lv_inc < level_rdata) begin
						if (h_q == t_node) tfound_q <= 1'b1;
						if (qt_q < DEP_MAX) qt_q <= qt_q + 1'b1;
					end
					e_q <= nxt_q;
				end
				B_CUR_WR: i_q <= (i_q == LAST_NODE) ? '0 : i_inc;
				B_DFS_START: begin
					v_q     <= s_node;
					lv_q    <= '0;
					depth_q <= '0;
				end
				B_DFS_V: begin
					if (v_q == t_node) begin
						i_q <= '0;
						b_q <= '1;
					end
				end
				B_DFS_C:  e_q <= cur_rdata;
				B_DFS_EL: if (level_rdata != lv_inc) e_q <= nxt_q;
				B_DFS_PUSH: begin
					if (depth_q < DEP_MAX) begin
						depth_q <= depth_q + 1'b1;
						v_q     <= h_q;
						lv_q    <= lv_inc;
					end
				end
				B_DFS_RET: begin
					if (depth_q != '0) depth_q <= depth_q - 1'b1;
					else i_q <= '0;
				end
				B_DFS_RW: pe_q  <= stk_rdata;
				B_DFS_RN: nxt_q <= ed_next;
				B_DFS_RT: begin
					v_q  <= ed_head;
					lv_q <= lv_q - 1'b1;
				end
				B_AUG_S: pe_q <= stk_rdata;
				B_AUG_M: begin
					if (res32 < b_q) b_q <= res32;
					i_q <= i_last ? '0 : i_inc;
				end
				B_UPD_S: pe_q <= stk_rdata;
				B_UPD_G: begin
					if (i_last) begin
						total_q <= total_q + FLOW_OUT_W'(b_q);
						v_q     <= s_node;
						lv_q    <= '0;
						depth_q <= '0;
						i_q     <= '0;
					end else begin
						i_q <= i_inc;
					end
				end
				B_DONE: begin
					if (load) begin
						fv_q  <= '0;
						cnt_q <= '0;
						err_q <= 1'b0;
					end
				end
				default: ;
			endcase

			// result register parts the engine from the output side
			if (load) begin
				out_valid_q <= 1'b1;
				out_flow_q  <= tb_q ? '0 : total_q;
				out_err_q   <= err_q | tb_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	mfd_ram #(.WIDTH(EW), .DEPTH(2 * MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	mfd_ram #(.WIDTH(FW), .DEPTH(2 * MAX_EDGES)) u_flow_ram (
		.clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
		.raddr(flow_raddr), .rdata(flow_rdata)
	);

	mfd_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_first_ram (
		.clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
		.raddr(first_raddr), .rdata(first_rdata)
	);

	mfd_ram #(.WIDTH(LVL_W), .DEPTH(MAX_NODES)) u_level_ram (
		.clk(clk), .we(level_we), .waddr(level_waddr), .wdata(level_wdata),
		.raddr(level_raddr), .rdata(level_rdata)
	);

	mfd_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_cur_ram (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.raddr(cur_raddr), .rdata(cur_rdata)
	);

	mfd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_bfs_ram (
		.clk(clk), .we(bq_we), .waddr(bq_waddr), .wdata(bq_wdata),
		.raddr(bq_raddr), .rdata(bq_rdata)
	);

	mfd_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	`MFD_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_MAX)
	`MFD_ASSERT_NEVER(a_depth_range, depth_q > DEP_MAX)
	`MFD_ASSERT_NEVER(a_queue_order, qh_q > qt_q)
	`MFD_ASSERT_NEXT(a_done_hold, state_q == B_DONE && out_valid_q && !m_tready, state_q == B_DONE)

endmodule

`default_nettype wire

// ----- src/max_flow_dinic.sv -----
// ---------------------------------------------------------------------------
// max_flow_dinic: maximum flow over a streamed edge list
// edge words are taken one per cycle while the 4-word queue has room; the
// engine stores a kept edge in the states idle, link_rd0, link_wr0, link_rd1
// and link_wr1 (a dropped edge only in idle), so longer bursts stall
// the word with tlast starts the sequencer: each phase clears all levels, runs
// the bfs, points each node at its first edge, then augments along blocking paths
// asynchronous reset: registers to defaults, graph empty (valid bits only)
// ---------------------------------------------------------------------------
`default_nettype none

module max_flow_dinic import mfd_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// register port: node_count at 0x0, source_node at 0x4, sink_node at 0x8
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// edge words
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // from_node[5:0], to_node[11:6], capacity[43:12]
	input  wire logic                  s_tlast,   // last_edge
	// result words
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [FLOW_OUT_W-1:0]      m_tdata,   // max_flow[39:0]
	output logic                       m_tuser    // input_error
);

	item_t push_item;
	item_t pop_item;
	cfg_t  cfg;
	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;

	// front: register file and edge classification
	mfd_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item),
		.cfg      (cfg)
	);

	// decoupling queue, lets intake run while the engine stores edges
	mfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	// back: graph store, dinic sequencer and result register
	mfd_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
